FILE: src/tch_pkg.sv
`timescale 1ns / 1ps

package tch_pkg;

  // Default number of CORDIC micro-rotations per unit
  localparam int CORDIC_STEPS_DEF = 16;

  // Field and register widths
  localparam int MAG_W    = 16;
  localparam int ADC_W    = 10;
  localparam int HEAD_W   = 15;
  localparam int ANG_W    = 32;   // binary angle, 2^32 per turn

  // Datapath widths
  localparam int ACC_W    = 30;   // accel vectors scaled by 2^16, plus CORDIC growth
  localparam int ROT_W    = 34;   // sin/cos rotation datapath and angle
  localparam int TRIG_W   = 32;   // Q30 sin/cos results
  localparam int CM_W     = 50;   // horizontal field components, Q30
  localparam int HDG_W    = 52;   // heading vectoring datapath

  localparam logic [ADC_W-1:0] OFFSET_RESET = 10'd355;
  localparam logic [ANG_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [ROT_W-1:0] INV_GAIN_Q30 = 34'd652032874;
  localparam logic [HEAD_W-1:0] FULL_TURN_UNITS = 15'd23040;

  // atan(2^-i) as a binary angle
  function automatic logic [ANG_W-1:0] atan_entry(input int unsigned i);
    logic [ANG_W-1:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: src/tch_cordic.sv
`timescale 1ns / 1ps

// Pipelined CORDIC, one micro-rotation per register stage.
// Vectoring mode drives y to zero and accumulates angle in z;
// rotation mode drives z to zero.
module tch_cordic #(
  parameter int W         = 32,
  parameter int ZW        = 32,
  parameter int STEPS     = 16,
  parameter bit VECTORING = 1'b1,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [W-1:0]      x_in,
  input  logic signed [W-1:0]      y_in,
  input  logic [ZW-1:0]            z_in,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic signed [W-1:0]      x_out,
  output logic signed [W-1:0]      y_out,
  output logic [ZW-1:0]            z_out,
  output logic [SIDE_W-1:0]        side_out
);
  import tch_pkg::*;

  logic signed [W-1:0] xs [STEPS+1];
  logic signed [W-1:0] ys [STEPS+1];
  logic [ZW-1:0]       zs [STEPS+1];
  logic [SIDE_W-1:0]   ss [STEPS+1];
  logic [STEPS:0]      vs;

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ss[0] = side_in;
  assign vs[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0] dx, dy;
    logic [ZW-1:0]       da;
    logic                pos;

    always_comb begin
      dx  = ys[i] >>> i;
      dy  = xs[i] >>> i;
      da  = ZW'(atan_entry(i));
      pos = VECTORING ? ~ys[i][W-1] : ~zs[i][ZW-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    // one micro-rotation
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i+1] <= ss[i];
        if (VECTORING) begin
          xs[i+1] <= pos ? xs[i] + dx : xs[i] - dx;
          ys[i+1] <= pos ? ys[i] - dy : ys[i] + dy;
          zs[i+1] <= pos ? zs[i] + da : zs[i] - da;
        end else begin
          xs[i+1] <= pos ? xs[i] - dx : xs[i] + dx;
          ys[i+1] <= pos ? ys[i] + dy : ys[i] - dy;
          zs[i+1] <= pos ? zs[i] - da : zs[i] + da;
        end
      end
    end
  end

  assign out_valid = vs[STEPS];
  assign x_out     = xs[STEPS];
  assign y_out     = ys[STEPS];
  assign z_out     = zs[STEPS];
  assign side_out  = ss[STEPS];

endmodule

FILE: src/tilt_compensated_heading_core.sv
`timescale 1ns / 1ps

// Tilt-compensated compass heading. Each accepted item (three signed
// magnetometer axes, three raw accelerometer ADC readings) yields one
// heading in 1/64 degree (0..23039). The block accepts one item per clock
// while sample_stall is low. Three CORDIC pipelines run in series
// (roll/pitch angles, their sin/cos, then the heading angle), each one
// stage per micro-rotation.
// A one-entry skid buffer behind the output register holds the pipeline
// when the consumer stalls. accel_zero_offset is written through
// cfg_write_en / cfg_write_data and resets to 355.
module tilt_compensated_heading_core #(
  parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [tch_pkg::ADC_W-1:0]          cfg_write_data,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [tch_pkg::MAG_W-1:0]   mag_x,
  input  logic signed [tch_pkg::MAG_W-1:0]   mag_y,
  input  logic signed [tch_pkg::MAG_W-1:0]   mag_z,
  input  logic [tch_pkg::ADC_W-1:0]          accel_x_raw,
  input  logic [tch_pkg::ADC_W-1:0]          accel_y_raw,
  input  logic [tch_pkg::ADC_W-1:0]          accel_z_raw,
  output logic                               heading_valid,
  input  logic                               heading_stall,
  output logic [tch_pkg::HEAD_W-1:0]         heading_angle
);
  import tch_pkg::*;

  localparam int MAGS_W = 3 * MAG_W;

  logic en;
  logic skid_full;
  logic [HEAD_W-1:0] skid_data;
  logic [ADC_W-1:0] accel_zero_offset;

  assign en           = ~skid_full;
  assign sample_stall = skid_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_zero_offset <= OFFSET_RESET;
    end else if (cfg_write_en) begin
      accel_zero_offset <= cfg_write_data;
    end
  end

  // stage 0: center accelerometer readings
  logic v0;
  logic signed [ADC_W:0] ax0, ay0, az0;
  logic [MAGS_W-1:0] m0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= $signed({1'b0, accel_zero_offset}) - $signed({1'b0, accel_x_raw});
      ay0 <= $signed({1'b0, accel_zero_offset}) - $signed({1'b0, accel_y_raw});
      az0 <= $signed({1'b0, accel_z_raw}) - $signed({1'b0, accel_zero_offset});
      m0  <= {mag_x, mag_y, mag_z};
    end
  end

  // stage 1: vectoring set-up for roll and pitch
  logic v1;
  logic signed [ACC_W-1:0] azs, axs, ays;
  logic signed [ACC_W-1:0] rx1, ry1, py1;
  logic [ANG_W-1:0] a1;
  logic zr1, zp1;
  logic [MAGS_W-1:0] m1;

  always_comb begin
    azs = ACC_W'(az0) <<< 16;
    axs = ACC_W'(ax0) <<< 16;
    ays = ACC_W'(ay0) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1 <= azs[ACC_W-1] ? -azs : azs;
      ry1 <= azs[ACC_W-1] ? -axs : axs;
      py1 <= azs[ACC_W-1] ? -ays : ays;
      a1  <= azs[ACC_W-1] ? TURN_HALF : '0;
      zr1 <= (az0 == '0) && (ax0 == '0);
      zp1 <= (az0 == '0) && (ay0 == '0);
      m1  <= m0;
    end
  end

  // roll and pitch angles
  logic vr_out, vp_out;
  logic signed [ACC_W-1:0] rx_o, ry_o, px_o, py_o;
  logic [ANG_W-1:0] roll_a, pitch_a;
  logic [MAGS_W:0] r_side;
  logic [0:0] p_side;

  tch_cordic #(
    .W(ACC_W), .ZW(ANG_W), .STEPS(CORDIC_STEPS), .VECTORING(1'b1), .SIDE_W(MAGS_W + 1)
  ) u_roll_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .x_in(rx1), .y_in(ry1), .z_in(a1), .side_in({zr1, m1}),
    .out_valid(vr_out), .x_out(rx_o), .y_out(ry_o), .z_out(roll_a), .side_out(r_side)
  );

  tch_cordic #(
    .W(ACC_W), .ZW(ANG_W), .STEPS(CORDIC_STEPS), .VECTORING(1'b1), .SIDE_W(1)
  ) u_pitch_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .x_in(rx1), .y_in(py1), .z_in(a1), .side_in(zp1),
    .out_valid(vp_out), .x_out(px_o), .y_out(py_o), .z_out(pitch_a), .side_out(p_side)
  );

  // stage 2: fold angles into +-90 degrees for sin/cos
  logic v2;
  logic [ROT_W-1:0] zr2, zp2;
  logic fr2, fp2;
  logic [MAGS_W-1:0] m2;
  logic [ANG_W-1:0] roll_sel, pitch_sel;
  logic signed [ROT_W-1:0] zr_s, zp_s;
  logic signed [ROT_W-1:0] quarter, half;
  logic unused_vec;

  always_comb begin
    roll_sel  = r_side[MAGS_W] ? '0 : roll_a;
    pitch_sel = p_side[0] ? '0 : pitch_a;
    zr_s      = ROT_W'($signed(roll_sel));
    zp_s      = ROT_W'($signed(pitch_sel));
    quarter   = ROT_W'(33'sh0_4000_0000);
    half      = ROT_W'(33'sh0_8000_0000);
    unused_vec = ^{rx_o, ry_o, px_o, py_o};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vr_out & vp_out & (unused_vec | ~unused_vec);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= r_side[MAGS_W-1:0];
      if (zr_s > quarter) begin
        zr2 <= zr_s - half;
        fr2 <= 1'b1;
      end else if (zr_s < -quarter) begin
        zr2 <= zr_s + half;
        fr2 <= 1'b1;
      end else begin
        zr2 <= zr_s;
        fr2 <= 1'b0;
      end
      if (zp_s > quarter) begin
        zp2 <= zp_s - half;
        fp2 <= 1'b1;
      end else if (zp_s < -quarter) begin
        zp2 <= zp_s + half;
        fp2 <= 1'b1;
      end else begin
        zp2 <= zp_s;
        fp2 <= 1'b0;
      end
    end
  end

  // sin/cos of roll and pitch
  logic vrr, vpr;
  logic signed [ROT_W-1:0] crx, cry, cpx, cpy;
  logic [ROT_W-1:0] zr_o, zp_o;
  logic [MAGS_W:0] rr_side;
  logic [0:0] pr_side;

  tch_cordic #(
    .W(ROT_W), .ZW(ROT_W), .STEPS(CORDIC_STEPS), .VECTORING(1'b0), .SIDE_W(MAGS_W + 1)
  ) u_roll_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .x_in(INV_GAIN_Q30), .y_in('0), .z_in(zr2), .side_in({fr2, m2}),
    .out_valid(vrr), .x_out(crx), .y_out(cry), .z_out(zr_o), .side_out(rr_side)
  );

  tch_cordic #(
    .W(ROT_W), .ZW(ROT_W), .STEPS(CORDIC_STEPS), .VECTORING(1'b0), .SIDE_W(1)
  ) u_pitch_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .x_in(INV_GAIN_Q30), .y_in('0), .z_in(zp2), .side_in(fp2),
    .out_valid(vpr), .x_out(cpx), .y_out(cpy), .z_out(zp_o), .side_out(pr_side)
  );

  // stage 3: undo the half-turn fold
  logic v3;
  logic signed [TRIG_W-1:0] cr3, sr3, cp3, sp3;
  logic signed [ROT_W-1:0] crn, srn, cpn, spn;
  logic signed [MAG_W-1:0] mx3, my3, mz3;
  logic unused_rot;

  always_comb begin
    crn = rr_side[MAGS_W] ? -crx : crx;
    srn = rr_side[MAGS_W] ? -cry : cry;
    cpn = pr_side[0] ? -cpx : cpx;
    spn = pr_side[0] ? -cpy : cpy;
    unused_rot = ^{zr_o, zp_o};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vrr & vpr & (unused_rot | ~unused_rot);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr3 <= crn[TRIG_W-1:0];
      sr3 <= srn[TRIG_W-1:0];
      cp3 <= cpn[TRIG_W-1:0];
      sp3 <= spn[TRIG_W-1:0];
      {mx3, my3, mz3} <= rr_side[MAGS_W-1:0];
    end
  end

  // stage 4: field products
  localparam int P_W = MAG_W + TRIG_W;
  logic v4;
  logic signed [P_W-1:0] p_mysr, p_mzcr, p_mxcp, p_mycr, p_mzsr;
  logic signed [TRIG_W-1:0] sp4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mysr <= my3 * sr3;
      p_mzcr <= mz3 * cr3;
      p_mxcp <= mx3 * cp3;
      p_mycr <= my3 * cr3;
      p_mzsr <= mz3 * sr3;
      sp4    <= sp3;
    end
  end

  // stage 5: combine, scale term for pitch product
  localparam int TS_W = P_W - 15;
  logic v5;
  logic signed [P_W-1:0] t_full, t_sh;
  logic signed [TS_W-1:0] ts5;
  logic signed [P_W-1:0] mxcp5, cmy5;
  logic signed [TRIG_W-1:0] sp5;

  always_comb begin
    t_full = p_mysr - p_mzcr;
    t_sh   = t_full >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts5   <= t_sh[TS_W-1:0];
      mxcp5 <= p_mxcp;
      cmy5  <= p_mycr + p_mzsr;
      sp5   <= sp4;
    end
  end

  // stage 6: times sin(pitch)
  localparam int Q_W = TS_W + TRIG_W;
  logic v6;
  logic signed [Q_W-1:0] q6;
  logic signed [P_W-1:0] mxcp6, cmy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q6    <= ts5 * sp5;
      mxcp6 <= mxcp5;
      cmy6  <= cmy5;
    end
  end

  // stage 7: horizontal field components
  logic v7;
  logic signed [Q_W-1:0] q_sh;
  logic signed [CM_W-1:0] cmx7;
  logic signed [P_W-1:0] cmy7;

  assign q_sh = q6 >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmx7 <= CM_W'(mxcp6) + q_sh[CM_W-1:0];
      cmy7 <= cmy6;
    end
  end

  // stage 8: vectoring set-up for heading
  logic v8;
  logic signed [HDG_W-1:0] hx_s, hy_s, hx8, hy8;
  logic [ANG_W-1:0] ha8;
  logic hz8;

  always_comb begin
    hx_s = HDG_W'(cmx7);
    hy_s = HDG_W'(cmy7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx8 <= hx_s[HDG_W-1] ? -hx_s : hx_s;
      hy8 <= hx_s[HDG_W-1] ? -hy_s : hy_s;
      ha8 <= hx_s[HDG_W-1] ? TURN_HALF : '0;
      hz8 <= (cmx7 == '0) && (cmy7 == '0);
    end
  end

  // heading angle
  logic vh;
  logic signed [HDG_W-1:0] hx_o, hy_o;
  logic [ANG_W-1:0] head_a;
  logic [0:0] h_side;

  tch_cordic #(
    .W(HDG_W), .ZW(ANG_W), .STEPS(CORDIC_STEPS), .VECTORING(1'b1), .SIDE_W(1)
  ) u_head_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(v8),
    .x_in(hx8), .y_in(hy8), .z_in(ha8), .side_in(hz8),
    .out_valid(vh), .x_out(hx_o), .y_out(hy_o), .z_out(head_a), .side_out(h_side)
  );

  // stage 9: heading = half turn - atan2
  logic v9;
  logic [ANG_W-1:0] h9;
  logic unused_head;

  assign unused_head = ^{hx_o, hy_o};

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= vh & (unused_head | ~unused_head);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h9 <= TURN_HALF - (h_side[0] ? '0 : head_a);
    end
  end

  // stage 10: scale to 1/64 degree
  localparam int PR_W = ANG_W + HEAD_W;
  logic v10;
  logic [PR_W-1:0] prod10;
  logic [PR_W:0] prod_rnd;
  logic [HEAD_W:0] units_w;
  logic [HEAD_W-1:0] units;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod10 <= PR_W'(h9) * PR_W'(FULL_TURN_UNITS);
    end
  end

  // round, wrap a full turn to zero
  always_comb begin
    prod_rnd = {1'b0, prod10} + (PR_W + 1)'(TURN_HALF);
    units_w  = prod_rnd[PR_W:ANG_W];
    units    = (units_w >= (HEAD_W + 1)'(FULL_TURN_UNITS)) ? '0 : units_w[HEAD_W-1:0];
  end

  // output register with skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_valid <= 1'b0;
      skid_full     <= 1'b0;
    end else if (!heading_valid || !heading_stall) begin
      if (skid_full) begin
        heading_valid <= 1'b1;
        heading_angle <= skid_data;
        skid_full     <= 1'b0;
      end else begin
        heading_valid <= v10;
        heading_angle <= units;
      end
    end else if (v10 && !skid_full) begin
      skid_full <= 1'b1;
      skid_data <= units;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tch_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = 3 * STEPS + 12;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [ADC_W-1:0] cfg_write_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [MAG_W-1:0] mag_x = '0, mag_y = '0, mag_z = '0;
  logic [ADC_W-1:0] accel_x_raw = '0, accel_y_raw = '0, accel_z_raw = '0;
  logic heading_valid;
  logic heading_stall = 1'b0;
  logic [HEAD_W-1:0] heading_angle;

  int errors = 0;
  int items_sent = 0;
  int headings_seen = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  tilt_compensated_heading_core uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .accel_x_raw(accel_x_raw), .accel_y_raw(accel_y_raw),
    .accel_z_raw(accel_z_raw),
    .heading_valid(heading_valid), .heading_stall(heading_stall),
    .heading_angle(heading_angle)
  );

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Heading predictor and store of expected headings
  class heading_scoreboard;
    logic [ADC_W-1:0] zero_offset;
    logic [HEAD_W-1:0] pending[$];

    function new();
      zero_offset = OFFSET_RESET;
    endfunction

    static function longint sra(longint v, int s);
      return v >>> s;
    endfunction

    // atan2 as a binary angle by vectoring rotation
    static function logic [31:0] vec_angle(longint x, longint y);
      logic [31:0] a;
      longint dx, dy;
      a = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        a = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = sra(y, i);
        dy = sra(x, i);
        if (y >= 0) begin
          x += dx;
          y -= dy;
          a += atan_entry(i);
        end else begin
          x -= dx;
          y += dy;
          a -= atan_entry(i);
        end
      end
      return a;
    endfunction

    // Q30 cos and sin
    static function void trig(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, dx, dy, t;
      bit flip;
      z = longint'(signed'(ang));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sh4000_0000) begin
        z -= 64'sh8000_0000;
        flip = 1;
      end else if (z < -64'sh4000_0000) begin
        z += 64'sh8000_0000;
        flip = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = sra(y, i);
        dy = sra(x, i);
        t = longint'(atan_entry(i));
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= t;
        end else begin
          x += dx;
          y -= dy;
          z += t;
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_sample(longint mx, longint my, longint mz,
                              longint rx, longint ry, longint rz);
      longint ax, ay, az, cr, sr, cp, sp, t, cmx, cmy, units;
      logic [31:0] roll, pitch, h;
      logic [63:0] prod;
      ax = longint'(zero_offset) - rx;
      ay = longint'(zero_offset) - ry;
      az = rz - longint'(zero_offset);
      roll = vec_angle(az * 65536, ax * 65536);
      pitch = vec_angle(az * 65536, ay * 65536);
      trig(roll, cr, sr);
      trig(pitch, cp, sp);
      t = my * sr - mz * cr;
      cmx = mx * cp + sra(sra(t, 15) * sp, 15);
      cmy = my * cr + mz * sr;
      h = 32'h8000_0000 - vec_angle(cmx, cmy);
      prod = 64'(h) * 64'd23040 + 64'h8000_0000;
      units = longint'(prod >> 32);
      if (units >= 23040) units = 0;
      pending.push_back(units[HEAD_W-1:0]);
    endfunction

    task check_heading(logic [HEAD_W-1:0] got);
      logic [HEAD_W-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected heading %0d", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want)
        report($sformatf("heading_angle got %0d want %0d", got, want));
    endtask
  endclass

  heading_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: check on rising edge, randomize stall on falling edge
  always @(posedge clk) begin
    cycles++;
    if (!rst && heading_valid && !heading_stall) begin
      sb.check_heading(heading_angle);
      headings_seen++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk)
    heading_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic write_offset(input logic [ADC_W-1:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.zero_offset = v;
  endtask

  // Present one item and hold it until accepted; valid stays up for the next one
  task automatic send_sample(input logic [MAG_W-1:0] mx, my, mz,
                             input logic [ADC_W-1:0] rx, ry, rz);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    mag_x <= mx;
    mag_y <= my;
    mag_z <= mz;
    accel_x_raw <= rx;
    accel_y_raw <= ry;
    accel_z_raw <= rz;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(longint'(signed'(mx)), longint'(signed'(my)), longint'(signed'(mz)),
                   longint'(rx), longint'(ry), longint'(rz));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [ADC_W-1:0] near(logic [ADC_W-1:0] c);
    int v;
    v = int'(c) + $urandom_range(80) - 40;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[ADC_W-1:0];
  endfunction

  task automatic random_phase(input int n, input logic [ADC_W-1:0] off);
    logic [MAG_W-1:0] m[3];
    logic [ADC_W-1:0] a[3];
    for (int k = 0; k < n; k++) begin
      foreach (m[j]) m[j] = MAG_W'($urandom);
      if (($urandom_range(9)) == 0) m[$urandom_range(2)] = '0;
      foreach (a[j]) a[j] = ($urandom_range(1)) ? near(off) : ADC_W'($urandom);
      // occasional level or exactly centered readings
      if ($urandom_range(15) == 0) a[0] = off;
      if ($urandom_range(15) == 0) a[2] = off;
      send_sample(m[0], m[1], m[2], a[0], a[1], a[2]);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, zero vectors, level readings at reset offset
    send_sample(16'h7FFF, 16'h8000, 16'h0000, 10'd355, 10'd355, 10'd355);
    send_sample(16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 10'd355, 10'd355, 10'd355);
    send_sample(16'h8000, 16'h8000, 16'h8000, 10'd1023, 10'd1023, 10'd1023);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0, 10'd1023, 10'd0);
    send_sample(16'h0001, 16'h0000, 16'h0000, 10'd355, 10'd355, 10'd600);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 10'd355, 10'd355, 10'd100);
    send_sample(16'h0000, 16'h0001, 16'h0000, 10'd355, 10'd355, 10'd600);
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 10'd355, 10'd355, 10'd600);
    send_sample(16'h1000, 16'h0000, 16'h7FFF, 10'd100, 10'd355, 10'd355);
    send_sample(16'h1000, 16'h2000, 16'h8000, 10'd355, 10'd700, 10'd355);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 10'd341, 10'd682, 10'd512);
    drain();

    // offset extremes, each with sender/receiver idling patterns
    write_offset(10'd0);
    send_sample(16'h7FFF, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0);
    send_sample(16'h0100, 16'h0100, 16'h0100, 10'd1023, 10'd1023, 10'd1023);
    send_idle_pct = 7;
    recv_idle_pct = 53;
    random_phase(120, 10'd0);
    drain();

    write_offset(10'd1023);
    send_sample(16'h7FFF, 16'h0000, 16'h0000, 10'd1023, 10'd1023, 10'd1023);
    send_sample(16'h8000, 16'h7FFF, 16'h0100, 10'd0, 10'd0, 10'd0);
    send_idle_pct = 53;
    recv_idle_pct = 7;
    random_phase(120, 10'd1023);
    drain();

    write_offset(10'd512);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130, 10'd512);
    drain();

    write_offset(10'd355);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    random_phase(110, 10'd355);
    drain();

    $display("sent %0d sample sets over offsets 355, 0, 1023, 512; %0d headings checked",
             items_sent, headings_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/tch_pkg.sv
src/tch_cordic.sv
src/tilt_compensated_heading_core.sv
sim/tb.sv
